### hw/rtl/knc_pkg.sv
// Shared types and constants for the k-means nearest-centroid unit.
package knc_pkg;

	localparam int SEL_W     = 3;
	localparam int IDX_W     = 5;
	localparam int VAL_W     = 16;
	localparam int NEAREST_W = 3;
	localparam int DIST_W    = 48;
	// cluster tag carried along the chain, wide enough for the largest row
	localparam int CID_W     = 6;
	localparam int DIFF_W    = VAL_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int SQ_W      = 2 * VAL_W + 1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic                    command;
		logic [SEL_W-1:0]        cluster_select;
		logic [IDX_W-1:0]        element_index;
		logic signed [VAL_W-1:0] element_value;
		logic                    last_element;
	} item_t;

	typedef struct packed {
		logic [NEAREST_W-1:0] nearest_cluster;
		logic [DIST_W-1:0]    squared_distance;
	} result_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} chain_item_t;

	typedef struct packed {
		logic              valid;
		logic [CID_W-1:0]  cluster;
		logic [DIST_W-1:0] sq_dist;
	} best_t;

endpackage

### hw/rtl/knc_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
interface knc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/knc_cell.sv
// One centroid cell: element store, squared-difference accumulator, running minimum.
module knc_cell
	import knc_pkg::*;
#(
	parameter int CELL_ID    = 0,
	parameter int DIMENSIONS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  chain_item_t item_in,
	input  best_t       best_in,
	output chain_item_t item_out,
	output best_t       best_out
);

	localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

	logic signed [VAL_W-1:0] mem [DIMENSIONS];

	logic [AW-1:0] addr;
	logic          in_range;
	logic          is_load;
	logic          is_point;
	logic          wr_en;

	assign addr     = AW'(item_in.item.element_index);
	assign in_range = 32'(item_in.item.element_index) < 32'(DIMENSIONS);
	assign is_load  = item_in.valid && (item_in.item.command == CMD_LOAD);
	assign is_point = item_in.valid && (item_in.item.command == CMD_POINT);
	assign wr_en    = en && is_load && in_range
		&& (32'(item_in.item.cluster_select) == 32'(CELL_ID));

	// stage 1: store read, item handed on to the next cell
	logic                    valid_s1;
	item_t                   itemp_s1;
	logic signed [VAL_W-1:0] rd_s1;
	logic                    pt_s1, last_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr] <= item_in.item.element_value;
		if (en) begin
			rd_s1    <= mem[addr];
			itemp_s1 <= item_in.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pt_s1    <= 1'b0;
			last_s1  <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_in.valid;
			pt_s1    <= is_point && in_range;
			last_s1  <= is_point && item_in.item.last_element;
		end
	end

	assign item_out = '{valid: valid_s1, item: itemp_s1};

	// stage 2: difference
	logic signed [DIFF_W-1:0] diff_s2;
	logic                     pt_s2, last_s2;

	always_ff @(posedge clk) begin
		if (en)
			diff_s2 <= DIFF_W'(itemp_s1.element_value) - DIFF_W'(rd_s1);
	end

	// stage 3: square
	logic signed [PROD_W-1:0] prod;
	logic [SQ_W-1:0]          sq_s3;
	logic                     pt_s3, last_s3;

	assign prod = diff_s2 * diff_s2;

	always_ff @(posedge clk) begin
		if (en)
			sq_s3 <= prod[SQ_W-1:0];
	end

	// stage 4: saturating accumulate, clear after the last element
	logic [DIST_W-1:0] acc_q;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] next_dist;
	logic [DIST_W-1:0] dist_s4;
	logic              res_s4;

	assign sum       = {1'b0, acc_q} + (DIST_W + 1)'(sq_s3);
	assign next_dist = !pt_s3 ? acc_q : (sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0]);

	always_ff @(posedge clk) begin
		if (en)
			dist_s4 <= next_dist;
	end

	// stage 5: compare against the best so far; strict less keeps the lower index
	logic              take_own;
	logic              best_valid_s5;
	logic [CID_W-1:0]  best_cluster_s5;
	logic [DIST_W-1:0] best_dist_s5;

	assign take_own = !best_in.valid || (dist_s4 < best_in.sq_dist);

	always_ff @(posedge clk) begin
		if (en) begin
			best_cluster_s5 <= take_own ? CID_W'(CELL_ID) : best_in.cluster;
			best_dist_s5    <= take_own ? dist_s4 : best_in.sq_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_s2         <= 1'b0;
			last_s2       <= 1'b0;
			pt_s3         <= 1'b0;
			last_s3       <= 1'b0;
			acc_q         <= '0;
			res_s4        <= 1'b0;
			best_valid_s5 <= 1'b0;
		end else if (en) begin
			pt_s2         <= pt_s1;
			last_s2       <= last_s1;
			pt_s3         <= pt_s2;
			last_s3       <= last_s2;
			acc_q         <= last_s3 ? '0 : next_dist;
			res_s4        <= last_s3;
			best_valid_s5 <= res_s4;
		end
	end

	assign best_out = '{valid: best_valid_s5, cluster: best_cluster_s5, sq_dist: best_dist_s5};

endmodule

### hw/rtl/kmeans_nearest_centroid_unit.sv
// Top level of the k-means nearest-centroid unit: a chain of centroid cells and an output register.
//
//  channel | dir | payload                                                   | transaction when
//  --------+-----+-----------------------------------------------------------+------------------
//  req     | in  | command, cluster_select, element_index, element_value,    | valid && ready
//          |     | last_element                                              |
//  rsp     | out | nearest_cluster, squared_distance                         | valid && ready
//
// One req transaction per cycle while req.ready is high, loads and point elements alike.
// After a point's last element is taken, the element walks one cell per cycle along
// the chain while it is not frozen; each cell passes it through store read, subtract,
// square, accumulate and compare, and the result then lands in the output register.
// Reset clears accumulators, stage valids and the output valid flag; the centroid
// store is not cleared and must be loaded before use.
// req.ready drops only while a finished result sits at the chain's end and the
// output register is still held by an untaken result; the whole chain then freezes.
module kmeans_nearest_centroid_unit
	import knc_pkg::*;
#(
	parameter int CLUSTERS   = 8,
	parameter int DIMENSIONS = 24
) (
	input logic       clk,
	input logic       arst_n,
	knc_chan_if.sink   req,
	knc_chan_if.source rsp
);

	chain_item_t item_bus [CLUSTERS+1];
	best_t       best_bus [CLUSTERS+1];
	logic        en;

	logic    rsp_valid_q;
	result_t result_q;

	// chain advances unless a result would overwrite one still waiting
	assign en = !(best_bus[CLUSTERS].valid && rsp_valid_q && !rsp.ready);

	assign req.ready   = en;
	assign item_bus[0] = '{valid: req.valid, item: req.data};
	// nothing to beat at the head of the chain
	assign best_bus[0] = '0;

	for (genvar c = 0; c < CLUSTERS; c++) begin : g_cell
		knc_cell #(
			.CELL_ID    (c),
			.DIMENSIONS (DIMENSIONS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.item_in  (item_bus[c]),
			.best_in  (best_bus[c]),
			.item_out (item_bus[c+1]),
			.best_out (best_bus[c+1])
		);
	end

	// output register: frees the chain from the consumer's ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en && best_bus[CLUSTERS].valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && best_bus[CLUSTERS].valid) begin
			result_q.nearest_cluster  <= NEAREST_W'(best_bus[CLUSTERS].cluster);
			result_q.squared_distance <= best_bus[CLUSTERS].sq_dist;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = result_q;

	// item leaving the last cell is not needed further
	logic unused_tail;
	assign unused_tail = ^item_bus[CLUSTERS];

endmodule

### hw/rtl/knc_checker.sv
// Port-level checks for the nearest-centroid unit, bound to its top level.
module knc_checker
	import knc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    req_valid,
	input logic    req_ready,
	input logic    req_command,
	input logic    req_last,
	input logic    rsp_valid,
	input logic    rsp_ready,
	input result_t rsp_data
);

	// last point elements taken but not yet answered
	logic [15:0] pending_q;
	logic        inc, dec;

	assign inc = req_valid && req_ready && (req_command == CMD_POINT) && req_last;
	assign dec = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 16'(inc) - 16'(dec);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before it was taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != '0)
		else $error("result without a pending last point element");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled while output is free");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("result present out of reset");

endmodule

bind kmeans_nearest_centroid_unit knc_checker u_knc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_command (req.data.command),
	.req_last    (req.data.last_element),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_data    (rsp.data)
);
